@@ design/dere_pkg.sv @@
`default_nettype none

package dere_pkg;

    // Default size of the graph.
    localparam int VERTICES_DEF = 64;

    // Widths of the payload fields.
    localparam int CMD_W = 2;
    localparam int VTX_W = 6;
    localparam int CNT_OUT_W = 6;

    // Command codes of an input word.
    typedef enum logic [CMD_W-1:0] {
        CMD_ADD     = 2'd0,
        CMD_REMOVE  = 2'd1,
        CMD_REVERSE = 2'd2,
        CMD_CLEAR   = 2'd3
    } t_cmd;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_QUERY,
        ST_DECIDE,
        ST_INIT,
        ST_LOAD,
        ST_SHIFT,
        ST_ROUND,
        ST_DONE
    } t_state;

    // What a finished query pass is used for.
    typedef enum logic [1:0] {
        QK_FIRST,
        QK_REV,
        QK_FINAL
    } t_qkind;

    // Operation applied by every cell in the same cycle.
    typedef enum logic [2:0] {
        OP_HOLD,
        OP_CLEAR,
        OP_ADD,
        OP_DEL,
        OP_INIT,
        OP_LOAD,
        OP_SHIFT
    } t_cell_op;

    // Control broadcast from the sequencer to the cells.
    typedef struct packed {
        t_cell_op op;
        logic     s_ok;
        logic     t_ok;
    } t_cell_ctl;

    // Flags gathered by the query chain.
    typedef struct packed {
        logic adj_st;
        logic reach_st;
        logic reach_ts;
    } t_col;

    // Saturate a stored degree count to the output width.
    function automatic logic [CNT_OUT_W-1:0] sat_count(input logic [15:0] c);
        logic [CNT_OUT_W-1:0] r;
        if (c > 16'd63) begin
            r = 6'd63;
        end else begin
            r = c[CNT_OUT_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ design/dere_intf.sv @@
`default_nettype none

// Command channel.
interface dere_req_if;
    logic                        valid;
    logic                        ready;
    logic [dere_pkg::CMD_W-1:0]  cmd;
    logic [dere_pkg::VTX_W-1:0]  from_vertex;
    logic [dere_pkg::VTX_W-1:0]  to_vertex;

    modport source(output valid, cmd, from_vertex, to_vertex, input ready);
    modport sink(input valid, cmd, from_vertex, to_vertex, output ready);
endinterface

// Result channel.
interface dere_rsp_if;
    logic                            valid;
    logic                            ready;
    logic                            ok;
    logic                            edge_present;
    logic                            path_forward;
    logic                            path_backward;
    logic [dere_pkg::CNT_OUT_W-1:0]  in_count;
    logic [dere_pkg::CNT_OUT_W-1:0]  out_count;

    modport source(output valid, ok, edge_present, path_forward, path_backward,
                   in_count, out_count, input ready);
    modport sink(input valid, ok, edge_present, path_forward, path_backward,
                 in_count, out_count, output ready);
endinterface

`default_nettype wire

@@ design/dag_edge_reachability_engine_core.sv @@
`default_nettype none

// Channel   Port    Role    Word
// command   i_req   sink    cmd, from_vertex, to_vertex
// result    o_rsp   source  ok, edge_present, path_forward, path_backward,
//                           in_count, out_count
//
// One command at a time. A query pass down the cell chain runs before and
// after each change; a closure round around the cell ring repeats until a
// round changes no row. A reverse runs a remove and an add back to back.
// Reset is synchronous and restores the empty graph at once. The result
// register holds a word until taken while the next command is already
// accepted.
module dag_edge_reachability_engine_core #(
    parameter int VERTICES = dere_pkg::VERTICES_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    dere_req_if.sink    i_req,
    dere_rsp_if.source  o_rsp
);

    localparam int VW = $clog2(VERTICES);
    localparam int CW = $clog2(VERTICES);

    dere_pkg::t_cell_ctl ctl;
    logic [VW-1:0] ea, eb, qs, qt;

    logic [VERTICES-1:0] trav     [VERTICES];
    logic [VW-1:0]       trav_idx [VERTICES];
    dere_pkg::t_col      col      [VERTICES];
    logic [CW-1:0]       col_in   [VERTICES];
    logic [CW-1:0]       col_out  [VERTICES];
    logic [VERTICES-1:0] changed;

    // Sequencer.
    dere_ctrl #(
        .V  (VERTICES),
        .VW (VW),
        .CW (CW)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (i_req),
        .o_rsp     (o_rsp),
        .o_ctl     (ctl),
        .o_ea      (ea),
        .o_eb      (eb),
        .o_qs      (qs),
        .o_qt      (qt),
        .i_col     (col[VERTICES-1]),
        .i_col_in  (col_in[VERTICES-1]),
        .i_col_out (col_out[VERTICES-1]),
        .i_changed (|changed)
    );

    // Row of vertex cells; the ring closes from the last cell to the first.
    for (genvar g = 0; g < VERTICES; g++) begin : g_cell
        localparam int PREV = (g + VERTICES - 1) % VERTICES;

        dere_pkg::t_col cin;
        logic [CW-1:0]  cin_in;
        logic [CW-1:0]  cin_out;

        if (g == 0) begin : g_head
            assign cin     = '0;
            assign cin_in  = '0;
            assign cin_out = '0;
        end else begin : g_body
            assign cin     = col[g-1];
            assign cin_in  = col_in[g-1];
            assign cin_out = col_out[g-1];
        end

        dere_cell #(
            .V   (VERTICES),
            .IDX (g),
            .VW  (VW),
            .CW  (CW)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (ctl),
            .i_ea       (ea),
            .i_eb       (eb),
            .i_qs       (qs),
            .i_qt       (qt),
            .i_trav     (trav[PREV]),
            .i_trav_idx (trav_idx[PREV]),
            .o_trav     (trav[g]),
            .o_trav_idx (trav_idx[g]),
            .i_col      (cin),
            .i_col_in   (cin_in),
            .i_col_out  (cin_out),
            .o_col      (col[g]),
            .o_col_in   (col_in[g]),
            .o_col_out  (col_out[g]),
            .o_changed  (changed[g])
        );
    end

endmodule

`default_nettype wire

@@ design/dere_cell.sv @@
`default_nettype none

// One vertex of the graph: its adjacency row, reachability row and degree
// counts, plus one stage of the closure ring and one stage of the query chain.
module dere_cell #(
    parameter int V   = dere_pkg::VERTICES_DEF,
    parameter int IDX = 0,
    parameter int VW  = $clog2(V),
    parameter int CW  = $clog2(V)
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  dere_pkg::t_cell_ctl     i_ctl,
    input  wire  [VW-1:0]           i_ea,
    input  wire  [VW-1:0]           i_eb,
    input  wire  [VW-1:0]           i_qs,
    input  wire  [VW-1:0]           i_qt,
    input  wire  [V-1:0]            i_trav,
    input  wire  [VW-1:0]           i_trav_idx,
    output logic [V-1:0]            o_trav,
    output logic [VW-1:0]           o_trav_idx,
    input  dere_pkg::t_col          i_col,
    input  wire  [CW-1:0]           i_col_in,
    input  wire  [CW-1:0]           i_col_out,
    output dere_pkg::t_col          o_col,
    output logic [CW-1:0]           o_col_in,
    output logic [CW-1:0]           o_col_out,
    output logic                    o_changed
);

    localparam logic [VW-1:0] ME = VW'(IDX);
    localparam logic [V-1:0]  SELF_ROW = {{(V-1){1'b0}}, 1'b1} << IDX;

    logic [V-1:0]  r_adj, n_adj;
    logic [V-1:0]  r_reach, n_reach;
    logic [CW-1:0] r_in, n_in;
    logic [CW-1:0] r_out, n_out;
    logic [V-1:0]  r_trav;
    logic [VW-1:0] r_trav_idx;
    dere_pkg::t_col r_col;
    logic [CW-1:0] r_col_in;
    logic [CW-1:0] r_col_out;

    logic          a_hit;
    logic          b_hit;
    logic          s_hit;
    logic          t_hit;
    logic [V-1:0]  merged;

    assign a_hit = (i_ea == ME);
    assign b_hit = (i_eb == ME);
    assign s_hit = i_ctl.s_ok && (i_qs == ME);
    assign t_hit = i_ctl.t_ok && (i_qt == ME);

    // Row that would result from the passing ring word.
    assign merged = r_reach[r_trav_idx] ? (r_reach | r_trav) : r_reach;

    // Next value of the stored row and counts.
    always_comb begin
        n_adj   = r_adj;
        n_reach = r_reach;
        n_in    = r_in;
        n_out   = r_out;
        unique case (i_ctl.op)
            dere_pkg::OP_CLEAR: begin
                n_adj   = '0;
                n_reach = SELF_ROW;
                n_in    = '0;
                n_out   = '0;
            end
            dere_pkg::OP_ADD: begin
                if (a_hit) begin
                    n_adj[i_eb]   = 1'b1;
                    n_reach[i_eb] = 1'b1;
                    n_out         = r_out + CW'(1);
                end
                if (b_hit) begin
                    n_in = r_in + CW'(1);
                end
            end
            dere_pkg::OP_DEL: begin
                if (a_hit) begin
                    n_adj[i_eb] = 1'b0;
                    n_out       = r_out - CW'(1);
                end
                if (b_hit) begin
                    n_in = r_in - CW'(1);
                end
            end
            dere_pkg::OP_INIT: begin
                n_reach = r_adj | SELF_ROW;
            end
            dere_pkg::OP_SHIFT: begin
                n_reach = merged;
            end
            dere_pkg::OP_HOLD, dere_pkg::OP_LOAD: begin
            end
            default: begin
            end
        endcase
    end

    assign o_changed = (i_ctl.op == dere_pkg::OP_SHIFT) && (merged != r_reach);

    // Graph state of this vertex.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_adj   <= '0;
            r_reach <= SELF_ROW;
            r_in    <= '0;
            r_out   <= '0;
        end else begin
            r_adj   <= n_adj;
            r_reach <= n_reach;
            r_in    <= n_in;
            r_out   <= n_out;
        end
    end

    // Closure ring stage: load own row, then pass the neighbor's word along.
    always_ff @(posedge i_clk) begin
        if (i_ctl.op == dere_pkg::OP_LOAD) begin
            r_trav     <= r_reach;
            r_trav_idx <= ME;
        end else if (i_ctl.op == dere_pkg::OP_SHIFT) begin
            r_trav     <= i_trav;
            r_trav_idx <= i_trav_idx;
        end
    end

    assign o_trav     = r_trav;
    assign o_trav_idx = r_trav_idx;

    // Query chain stage: add this vertex's answers to the passing word.
    always_ff @(posedge i_clk) begin
        r_col.adj_st   <= i_col.adj_st   | (s_hit && i_ctl.t_ok && r_adj[i_qt]);
        r_col.reach_st <= i_col.reach_st | (s_hit && i_ctl.t_ok && r_reach[i_qt]);
        r_col.reach_ts <= i_col.reach_ts | (t_hit && i_ctl.s_ok && r_reach[i_qs]);
        r_col_in       <= i_col_in  | (t_hit ? r_in  : CW'(0));
        r_col_out      <= i_col_out | (s_hit ? r_out : CW'(0));
    end

    assign o_col     = r_col;
    assign o_col_in  = r_col_in;
    assign o_col_out = r_col_out;

endmodule

`default_nettype wire

@@ design/dere_ctrl.sv @@
`default_nettype none

// Command sequencer: query pass, decision, edge update, closure rounds,
// final query and the result register.
module dere_ctrl #(
    parameter int V  = dere_pkg::VERTICES_DEF,
    parameter int VW = $clog2(V),
    parameter int CW = $clog2(V)
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    dere_req_if.sink             i_req,
    dere_rsp_if.source           o_rsp,
    output dere_pkg::t_cell_ctl  o_ctl,
    output logic [VW-1:0]        o_ea,
    output logic [VW-1:0]        o_eb,
    output logic [VW-1:0]        o_qs,
    output logic [VW-1:0]        o_qt,
    input  dere_pkg::t_col       i_col,
    input  wire  [CW-1:0]        i_col_in,
    input  wire  [CW-1:0]        i_col_out,
    input  wire                  i_changed
);

    localparam int CNTW = (V > 1) ? $clog2(V) : 1;
    localparam logic [CNTW-1:0] CNT_LAST = CNTW'(V - 1);

    dere_pkg::t_state r_state, n_state;
    dere_pkg::t_qkind r_qkind, n_qkind;
    dere_pkg::t_cmd   r_cmd;
    logic [CNTW-1:0]  r_cnt, n_cnt;
    logic [dere_pkg::VTX_W-1:0] r_s, r_t;
    logic             r_ok, n_ok;
    logic             r_dirty, n_dirty;
    logic             r_ovalid, n_ovalid;
    logic             s_ok, t_ok, both;
    logic             accept;
    logic             out_load;

    // Decision taken after a query pass.
    dere_pkg::t_cell_op d_op;
    dere_pkg::t_state   d_next;
    dere_pkg::t_qkind   d_qkind;
    logic               d_ok;
    logic               d_swap;

    assign s_ok = (32'(r_s) < V);
    assign t_ok = (32'(r_t) < V);
    assign both = s_ok && t_ok;
    assign o_qs = VW'(r_s);
    assign o_qt = VW'(r_t);

    assign i_req.ready = (r_state == dere_pkg::ST_IDLE);
    assign accept      = i_req.valid && i_req.ready;
    assign out_load    = (r_state == dere_pkg::ST_DONE) && (!r_ovalid || o_rsp.ready);

    // Decision from the gathered query flags.
    always_comb begin
        d_op    = dere_pkg::OP_HOLD;
        d_next  = dere_pkg::ST_DONE;
        d_qkind = dere_pkg::QK_FINAL;
        d_ok    = r_ok;
        d_swap  = 1'b0;
        unique case (r_qkind)
            dere_pkg::QK_FIRST: begin
                priority if (!both) begin
                    d_ok = 1'b0;
                end else if (r_cmd == dere_pkg::CMD_ADD) begin
                    if (i_col.adj_st || i_col.reach_ts) begin
                        d_ok = 1'b0;
                    end else begin
                        d_ok   = 1'b1;
                        d_op   = dere_pkg::OP_ADD;
                        d_next = dere_pkg::ST_LOAD;
                    end
                end else if (r_cmd == dere_pkg::CMD_REMOVE) begin
                    d_ok = 1'b1;
                    if (i_col.adj_st) begin
                        d_op   = dere_pkg::OP_DEL;
                        d_next = dere_pkg::ST_INIT;
                    end
                end else begin
                    // Reverse: only an existing edge can be turned around.
                    d_ok = 1'b0;
                    if (i_col.adj_st) begin
                        d_op    = dere_pkg::OP_DEL;
                        d_next  = dere_pkg::ST_INIT;
                        d_qkind = dere_pkg::QK_REV;
                    end
                end
            end
            dere_pkg::QK_REV: begin
                // Turn the edge around unless the source still reaches the target.
                d_next = dere_pkg::ST_LOAD;
                d_op   = dere_pkg::OP_ADD;
                d_ok   = !i_col.reach_st;
                d_swap = !i_col.reach_st;
            end
            dere_pkg::QK_FINAL: begin
            end
            default: begin
            end
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dere_pkg::ST_IDLE: begin
                if (accept) begin
                    n_state = dere_pkg::ST_QUERY;
                end
            end
            dere_pkg::ST_QUERY: begin
                if (r_cnt == CNT_LAST) begin
                    n_state = dere_pkg::ST_DECIDE;
                end
            end
            dere_pkg::ST_DECIDE: n_state = d_next;
            dere_pkg::ST_INIT:   n_state = dere_pkg::ST_LOAD;
            dere_pkg::ST_LOAD:   n_state = dere_pkg::ST_SHIFT;
            dere_pkg::ST_SHIFT: begin
                if (r_cnt == CNT_LAST) begin
                    n_state = dere_pkg::ST_ROUND;
                end
            end
            dere_pkg::ST_ROUND: begin
                n_state = r_dirty ? dere_pkg::ST_LOAD : dere_pkg::ST_QUERY;
            end
            dere_pkg::ST_DONE: begin
                if (out_load) begin
                    n_state = dere_pkg::ST_IDLE;
                end
            end
            default: n_state = dere_pkg::ST_IDLE;
        endcase
    end

    // Cell control and register updates.
    always_comb begin
        o_ctl.op   = dere_pkg::OP_HOLD;
        o_ctl.s_ok = s_ok;
        o_ctl.t_ok = t_ok;
        o_ea       = o_qs;
        o_eb       = o_qt;
        n_cnt      = '0;
        n_qkind    = r_qkind;
        n_ok       = r_ok;
        n_dirty    = r_dirty;
        n_ovalid   = r_ovalid && !o_rsp.ready;
        unique case (r_state)
            dere_pkg::ST_IDLE: begin
                if (accept) begin
                    if (dere_pkg::t_cmd'(i_req.cmd) == dere_pkg::CMD_CLEAR) begin
                        o_ctl.op = dere_pkg::OP_CLEAR;
                        n_ok     = 1'b1;
                        n_qkind  = dere_pkg::QK_FINAL;
                    end else begin
                        n_ok    = 1'b0;
                        n_qkind = dere_pkg::QK_FIRST;
                    end
                end
            end
            dere_pkg::ST_QUERY, dere_pkg::ST_SHIFT: begin
                n_cnt = r_cnt + CNTW'(1);
                if (r_state == dere_pkg::ST_SHIFT) begin
                    o_ctl.op = dere_pkg::OP_SHIFT;
                    n_dirty  = r_dirty || i_changed;
                end
            end
            dere_pkg::ST_DECIDE: begin
                o_ctl.op = d_op;
                n_ok     = d_ok;
                n_qkind  = d_qkind;
                if (d_swap) begin
                    o_ea = o_qt;
                    o_eb = o_qs;
                end
            end
            dere_pkg::ST_INIT: o_ctl.op = dere_pkg::OP_INIT;
            dere_pkg::ST_LOAD: begin
                o_ctl.op = dere_pkg::OP_LOAD;
                n_dirty  = 1'b0;
            end
            dere_pkg::ST_ROUND: begin
            end
            dere_pkg::ST_DONE: begin
                if (out_load) begin
                    n_ovalid = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= dere_pkg::ST_IDLE;
            r_qkind  <= dere_pkg::QK_FIRST;
            r_cnt    <= '0;
            r_ok     <= 1'b0;
            r_dirty  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_qkind  <= n_qkind;
            r_cnt    <= n_cnt;
            r_ok     <= n_ok;
            r_dirty  <= n_dirty;
            r_ovalid <= n_ovalid;
        end
    end

    // Latched command word.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= dere_pkg::t_cmd'(i_req.cmd);
            r_s   <= i_req.from_vertex;
            r_t   <= i_req.to_vertex;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            o_rsp.ok            <= r_ok;
            o_rsp.edge_present  <= i_col.adj_st;
            o_rsp.path_forward  <= i_col.reach_st;
            o_rsp.path_backward <= i_col.reach_ts;
            o_rsp.in_count      <= dere_pkg::sat_count(16'(i_col_in));
            o_rsp.out_count     <= dere_pkg::sat_count(16'(i_col_out));
        end
    end

    assign o_rsp.valid = r_ovalid;

endmodule

`default_nettype wire
